// ===== rtl/core/agr_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// agr_pkg: shared types and constants for the alternate group reverser
// Holds the stack geometry, the control structs exchanged between modules
// and the group size clamp.
// ----------------------------------------------------------------------------
package agr_pkg;

  // Stack depth and element width.
  localparam int GROUP_MAX  = 64;
  localparam int DATA_WIDTH = 32;

  // Width of the group size register.
  localparam int CFG_W = 7;

  // Stack address width and width of a count that can hold GROUP_MAX itself.
  localparam int ADDR_W = (GROUP_MAX > 1) ? $clog2(GROUP_MAX) : 1;
  localparam int CNT_W  = (GROUP_MAX > 1) ? $clog2(GROUP_MAX + 1) : 1;

  localparam logic [CFG_W-1:0] GROUP_SIZE_RESET = CFG_W'(2);

  typedef logic [DATA_WIDTH-1:0] agr_data_t;
  typedef logic [ADDR_W-1:0]     agr_addr_t;
  typedef logic [CNT_W-1:0]      agr_cnt_t;

  // Stack access request from the sequencer.
  typedef struct packed {
    logic      we;
    agr_addr_t waddr;
    agr_data_t wdata;
    logic      re;
    agr_addr_t raddr;
  } agr_mem_req_t;

  // Flags of the result waiting in the staging register.
  typedef struct packed {
    logic valid;
    logic run_last;
    logic seq_done;
  } agr_res_t;

  // Sequencer states, one-hot.
  typedef enum logic [1:0] {
    ST_COLLECT = 2'b01,
    ST_DRAIN   = 2'b10
  } agr_state_t;

  // Clamp the programmed group size into the range 1 to GROUP_MAX.
  function automatic agr_cnt_t eff_size(input logic [CFG_W-1:0] gs);
    agr_cnt_t k;
    if (gs == '0) begin
      k = CNT_W'(1);
    end else if (int'(gs) > GROUP_MAX) begin
      k = CNT_W'(GROUP_MAX);
    end else begin
      k = gs[CNT_W-1:0];
    end
    return k;
  endfunction

endpackage

// ===== rtl/core/agr_stack_mem.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// agr_stack_mem: group stack storage
// Synchronous memory with one write port and one read port. Read data is
// registered and holds its value while no read is issued.
// ----------------------------------------------------------------------------
module agr_stack_mem (
  input  logic                 clk,
  input  agr_pkg::agr_mem_req_t req,
  output agr_pkg::agr_data_t   rd_data
);

  agr_pkg::agr_data_t mem [agr_pkg::GROUP_MAX];

  // Write port.
  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
  end

  // Read port; read data is registered.
  always_ff @(posedge clk) begin
    if (req.re) begin
      rd_data <= mem[req.raddr];
    end
  end

endmodule

// ===== rtl/core/agr_seq.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// agr_seq: group sequencer
// Tracks the group phase and counts, pushes reversing values onto the stack,
// pops a finished group in reverse order and stages one result at a time.
// ----------------------------------------------------------------------------
module agr_seq (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_write,
  input  logic [agr_pkg::CFG_W-1:0]      cfg_data,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic signed [agr_pkg::DATA_WIDTH-1:0] value_in,
  input  logic                           end_of_sequence,
  output agr_pkg::agr_mem_req_t          mem_req,
  input  agr_pkg::agr_data_t             mem_rd_data,
  input  logic                           out_free,
  output agr_pkg::agr_res_t              res,
  output agr_pkg::agr_data_t             res_data
);

  agr_pkg::agr_state_t          state;
  logic [agr_pkg::CFG_W-1:0]    group_size;
  agr_pkg::agr_addr_t           fill_count;
  agr_pkg::agr_addr_t           pass_count;
  logic                         passing;
  agr_pkg::agr_addr_t           drain_slot;
  logic                         drain_eos;
  logic                         from_pass;
  agr_pkg::agr_data_t           pass_data;

  agr_pkg::agr_cnt_t            k;
  agr_pkg::agr_cnt_t            fill_inc;
  agr_pkg::agr_cnt_t            pass_inc;
  logic                         stage_free;
  logic                         accept;
  logic                         drain_issue;
  logic                         group_full;
  logic                         pass_full;

  // Handshake and stack control.
  assign k           = agr_pkg::eff_size(group_size);
  assign fill_inc    = agr_pkg::agr_cnt_t'(fill_count) + agr_pkg::agr_cnt_t'(1);
  assign pass_inc    = agr_pkg::agr_cnt_t'(pass_count) + agr_pkg::agr_cnt_t'(1);
  assign group_full  = (fill_inc >= k);
  assign pass_full   = (pass_inc >= k);
  assign stage_free  = !res.valid || out_free;
  assign in_ready    = (state == agr_pkg::ST_COLLECT) && stage_free;
  assign accept      = in_valid && in_ready;
  assign drain_issue = (state == agr_pkg::ST_DRAIN) && stage_free;

  assign mem_req.we    = accept && !passing;
  assign mem_req.waddr = fill_count;
  assign mem_req.wdata = value_in;
  assign mem_req.re    = drain_issue;
  assign mem_req.raddr = drain_slot;

  // A passed value comes from its own register, a popped one from the stack.
  assign res_data = from_pass ? pass_data : mem_rd_data;

  // Group size register.
  always_ff @(posedge clk) begin
    if (rst) begin
      group_size <= agr_pkg::GROUP_SIZE_RESET;
    end else if (cfg_write) begin
      group_size <= cfg_data;
    end
  end

  // Phase, counts and sequencer state.
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= agr_pkg::ST_COLLECT;
      fill_count <= '0;
      pass_count <= '0;
      passing    <= 1'b0;
      drain_slot <= '0;
      drain_eos  <= 1'b0;
    end else begin
      unique case (state)
        agr_pkg::ST_COLLECT: begin
          if (accept && passing) begin
            if (end_of_sequence || pass_full) begin
              passing    <= 1'b0;
              pass_count <= '0;
            end else begin
              pass_count <= pass_count + agr_pkg::agr_addr_t'(1);
            end
          end else if (accept) begin
            if (end_of_sequence || group_full) begin
              // Group closes: pop it back starting at the newest entry.
              state      <= agr_pkg::ST_DRAIN;
              drain_slot <= fill_count;
              drain_eos  <= end_of_sequence;
              fill_count <= '0;
              passing    <= !end_of_sequence;
              pass_count <= '0;
            end else begin
              fill_count <= fill_count + agr_pkg::agr_addr_t'(1);
            end
          end
        end
        agr_pkg::ST_DRAIN: begin
          if (drain_issue) begin
            if (drain_slot == '0) begin
              state <= agr_pkg::ST_COLLECT;
            end else begin
              drain_slot <= drain_slot - agr_pkg::agr_addr_t'(1);
            end
          end
        end
        default: begin
          state <= agr_pkg::ST_COLLECT;
        end
      endcase
    end
  end

  // Staging register in front of the output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      res.valid <= 1'b0;
    end else if (accept && passing) begin
      res.valid <= 1'b1;
    end else if (drain_issue) begin
      res.valid <= 1'b1;
    end else if (out_free) begin
      res.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && passing) begin
      from_pass    <= 1'b1;
      pass_data    <= value_in;
      res.run_last <= 1'b1;
      res.seq_done <= end_of_sequence;
    end else if (drain_issue) begin
      from_pass    <= 1'b0;
      res.run_last <= (drain_slot == '0);
      res.seq_done <= drain_eos && (drain_slot == '0);
    end
  end

  // The stack is never read and written in the same cycle.
  a_no_rw_overlap: assert property (@(posedge clk) disable iff (rst)
    !(mem_req.we && mem_req.re))
    else $error("stack read and write in the same cycle");

  // Popping the oldest entry ends the drain.
  a_drain_ends: assert property (@(posedge clk) disable iff (rst)
    (drain_issue && drain_slot == '0) |=> (state == agr_pkg::ST_COLLECT))
    else $error("drain did not end after the bottom entry");

  // A passing group never holds stack entries.
  a_pass_empty: assert property (@(posedge clk) disable iff (rst)
    passing |-> (fill_count == '0))
    else $error("stack not empty during a passing group");

  // A staged result holds while the output register is full.
  a_stage_hold: assert property (@(posedge clk) disable iff (rst)
    (res.valid && !out_free) |=> (res.valid && $stable(res_data)
      && $stable(res.run_last)))
    else $error("staged result changed while stalled");

endmodule

// ===== rtl/core/alternate_group_reverser_core.sv =====
`timescale 1ns / 1ps
// A passed value goes through the staging register and the output register;
// a closed reversing group is popped newest entry first, each value going
// from the stack read register to the output register. Popping makes one
// stack read a cycle while the staging register is free, and no input is
// taken until the group is popped. Reset clears the control state and sets
// group_size to 2; the stack is not cleared and needs no start-up pass.
// ----------------------------------------------------------------------------
// alternate_group_reverser_core: alternate group reverser, top level
// Connects the sequencer and the group stack and holds the output register
// that decouples the result channel from the popping logic.
// ----------------------------------------------------------------------------
module alternate_group_reverser_core (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  cfg_write,
  input  logic [agr_pkg::CFG_W-1:0]             cfg_data,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic signed [agr_pkg::DATA_WIDTH-1:0] value_in,
  input  logic                                  end_of_sequence,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic signed [agr_pkg::DATA_WIDTH-1:0] value_out,
  output logic                                  run_last,
  output logic                                  sequence_done
);

  agr_pkg::agr_mem_req_t mem_req;
  agr_pkg::agr_data_t    mem_rd_data;
  agr_pkg::agr_res_t     res;
  agr_pkg::agr_data_t    res_data;
  logic                  out_free;

  assign out_free = !out_valid || out_ready;

  // Sequencer.
  agr_seq u_seq (
    .clk             (clk),
    .rst             (rst),
    .cfg_write       (cfg_write),
    .cfg_data        (cfg_data),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .value_in        (value_in),
    .end_of_sequence (end_of_sequence),
    .mem_req         (mem_req),
    .mem_rd_data     (mem_rd_data),
    .out_free        (out_free),
    .res             (res),
    .res_data        (res_data)
  );

  // Group stack.
  agr_stack_mem u_stack (
    .clk     (clk),
    .req     (mem_req),
    .rd_data (mem_rd_data)
  );

  // Output register: loads the staged result whenever it is empty or drained.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= res.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free && res.valid) begin
      value_out     <= res_data;
      run_last      <= res.run_last;
      sequence_done <= res.seq_done;
    end
  end

endmodule

// ===== verif/alternate_group_reverser_core_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// alternate_group_reverser_core_tb: self-checking bench for the group reverser
// Streams signed values through the block under random valid and ready gaps.
// A scoreboard predicts the reversed and passed groups from each accepted
// transfer and checks every result in order. The group size is changed between
// phases, including in the middle of open groups.
// ----------------------------------------------------------------------------
module alternate_group_reverser_core_tb;

  localparam int RANDOM_ITEMS  = 300;
  localparam int QUIET_LIMIT   = 1000;
  localparam int SETTLE_CYCLES = 10;
  localparam int TAIL_CYCLES   = 20;
  localparam int MAX_PRINTS    = 50;

  localparam logic [agr_pkg::DATA_WIDTH-1:0] WORD_MIN  =
    {1'b1, {(agr_pkg::DATA_WIDTH-1){1'b0}}};
  localparam logic [agr_pkg::DATA_WIDTH-1:0] WORD_MAX  =
    {1'b0, {(agr_pkg::DATA_WIDTH-1){1'b1}}};
  localparam logic [agr_pkg::DATA_WIDTH-1:0] WORD_ZERO = '0;
  localparam logic [agr_pkg::DATA_WIDTH-1:0] WORD_ONES = '1;

  // One predicted result as it should appear on the output channel.
  typedef struct packed {
    logic [agr_pkg::DATA_WIDTH-1:0] value;
    logic                           run_last;
    logic                           seq_done;
  } group_word_t;

  // Scoreboard: tracks the group state and holds results still to arrive.
  class group_order_board;
    logic [agr_pkg::DATA_WIDTH-1:0] held_words [agr_pkg::GROUP_MAX];
    int unsigned                    fill;
    int unsigned                    passed;
    bit                             passing;
    logic [agr_pkg::CFG_W-1:0]      size_reg;
    group_word_t                    due_words [$];
    int unsigned                    mismatches;

    function new();
      size_reg   = agr_pkg::GROUP_SIZE_RESET;
      fill       = 0;
      passed     = 0;
      passing    = 1'b0;
      mismatches = 0;
    endfunction

    // Group length after clamping the register into 1 .. GROUP_MAX.
    function int unsigned group_len();
      if (size_reg == '0) begin
        return 1;
      end else if (int'(size_reg) > agr_pkg::GROUP_MAX) begin
        return agr_pkg::GROUP_MAX;
      end
      return int'(size_reg);
    endfunction

    function void set_size(logic [agr_pkg::CFG_W-1:0] v);
      size_reg = v;
    endfunction

    function int unsigned pending();
      return due_words.size();
    endfunction

    // Predict the results caused by one accepted input transfer.
    function void note_input(logic [agr_pkg::DATA_WIDTH-1:0] v, logic eos);
      int unsigned k;
      group_word_t w;
      k = group_len();
      if (passing) begin
        w.value    = v;
        w.run_last = 1'b1;
        w.seq_done = eos;
        due_words.push_back(w);
        passed++;
        if (eos) begin
          passing = 1'b0;
          passed  = 0;
          fill    = 0;
        end else if (passed >= k) begin
          passing = 1'b0;
          passed  = 0;
        end
        return;
      end
      held_words[fill] = v;
      fill++;
      if (fill < k && !eos) begin
        return;
      end
      // The group closes: pop it newest first.
      for (int i = int'(fill) - 1; i >= 0; i--) begin
        w.value    = held_words[i];
        w.run_last = (i == 0);
        w.seq_done = eos && (i == 0);
        due_words.push_back(w);
      end
      fill    = 0;
      passed  = 0;
      passing = !eos;
    endfunction

    task report(string msg);
      if (mismatches < MAX_PRINTS) begin
        $display("MISMATCH at %0t: %s", $realtime, msg);
      end
      mismatches++;
    endtask

    // Compare one output transfer with the oldest predicted result.
    task check_result(logic [agr_pkg::DATA_WIDTH-1:0] v, logic rl, logic sd);
      group_word_t w;
      if (due_words.size() == 0) begin
        report($sformatf("unexpected result value %h", v));
        return;
      end
      w = due_words.pop_front();
      if (v !== w.value) begin
        report($sformatf("value_out %h, predicted %h", v, w.value));
      end
      if (rl !== w.run_last) begin
        report($sformatf("run_last %b, predicted %b (value %h)", rl, w.run_last, w.value));
      end
      if (sd !== w.seq_done) begin
        report($sformatf("sequence_done %b, predicted %b (value %h)", sd, w.seq_done,
                         w.value));
      end
    endtask
  endclass

  logic                           clk;
  logic                           rst = 1'b1;
  logic                           cfg_write = 1'b0;
  logic [agr_pkg::CFG_W-1:0]      cfg_data = '0;
  logic                           in_valid = 1'b0;
  logic                           in_ready;
  logic [agr_pkg::DATA_WIDTH-1:0] value_in = '0;
  logic                           end_of_sequence = 1'b0;
  logic                           out_valid;
  logic                           out_ready = 1'b0;
  logic [agr_pkg::DATA_WIDTH-1:0] value_out;
  logic                           run_last;
  logic                           sequence_done;

  group_order_board sb = new();
  bit               idle_on = 1'b1;
  int unsigned      results_taken = 0;
  int unsigned      results_noted = 0;
  int unsigned      stall_left = 0;

  alternate_group_reverser_core dut (
    .clk             (clk),
    .rst             (rst),
    .cfg_write       (cfg_write),
    .cfg_data        (cfg_data),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .value_in        (value_in),
    .end_of_sequence (end_of_sequence),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .value_out       (value_out),
    .run_last        (run_last),
    .sequence_done   (sequence_done)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Monitor: check output transfers first, then predict from input transfers.
  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && out_ready) begin
        sb.check_result(value_out, run_last, sequence_done);
        results_taken++;
      end
      if (in_valid && in_ready) begin
        sb.note_input(value_in, end_of_sequence);
      end
    end
  end

  // Receiver: after each result transfer, hold ready low for a random stall while gaps are on.
  always @(negedge clk) begin
    if (results_taken != results_noted) begin
      results_noted = results_taken;
      stall_left = idle_on ? $urandom_range(0, 7) : 0;
    end
    if (stall_left > 0) begin
      out_ready <= 1'b0;
      stall_left--;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // Watchdog: end the run when no transfer happens for too long.
  initial begin
    int unsigned quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("simulation failed");
    $finish;
  end

  function automatic logic [agr_pkg::DATA_WIDTH-1:0] rand_word();
    case ($urandom_range(0, 9))
      0: return WORD_MIN;
      1: return WORD_MAX;
      2: return WORD_ZERO;
      3: return WORD_ONES;
      default: return agr_pkg::DATA_WIDTH'($urandom);
    endcase
  endfunction

  // Mostly small groups, sometimes large ones, zero or out-of-range values.
  function automatic logic [agr_pkg::CFG_W-1:0] pick_size();
    case ($urandom_range(0, 19))
      0: return '0;
      1: return agr_pkg::CFG_W'($urandom_range(agr_pkg::GROUP_MAX + 1,
                                                (1 << agr_pkg::CFG_W) - 1));
      2: return agr_pkg::CFG_W'(agr_pkg::GROUP_MAX);
      3, 4: return agr_pkg::CFG_W'($urandom_range(9, agr_pkg::GROUP_MAX - 1));
      default: return agr_pkg::CFG_W'($urandom_range(1, 8));
    endcase
  endfunction

  // Offer one item after a random gap and hold it until its transfer.
  // Called and returns at a falling edge.
  task automatic send_item(input logic [agr_pkg::DATA_WIDTH-1:0] v, input logic eos);
    int unsigned gap;
    gap = idle_on ? $urandom_range(0, 7) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid        <= 1'b1;
    value_in        <= v;
    end_of_sequence <= eos;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
  endtask

  // Stop sending and wait until every predicted result has come out.
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // Write the group size register while the block is idle.
  task automatic write_size(input logic [agr_pkg::CFG_W-1:0] v);
    wait_drained();
    cfg_write <= 1'b1;
    cfg_data  <= v;
    @(negedge clk);
    cfg_write <= 1'b0;
    sb.set_size(v);
  endtask

  initial begin
    int unsigned sent;
    int unsigned k;
    int unsigned n_seq;
    int unsigned len;
    bit          keep_open;

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Reset size of two: extremes reversed, then passed, a partial reversing
    // group at the end, and a sequence that ends inside a passing group.
    send_item(WORD_MIN, 1'b0);
    send_item(WORD_MAX, 1'b0);
    send_item(WORD_ZERO, 1'b0);
    send_item(WORD_ONES, 1'b0);
    send_item(32'hAAAA_AAAA, 1'b1);
    send_item(32'h5555_5555, 1'b0);
    send_item(32'h1234_5678, 1'b0);
    send_item(32'hEDCB_A987, 1'b1);

    // A size of zero behaves as one.
    write_size('0);
    send_item(32'h0000_0001, 1'b0);
    send_item(32'h8000_0001, 1'b0);
    send_item(32'hFFFF_FFFE, 1'b1);

    // All ones saturates; shrinking it mid-group flushes what is held.
    write_size('1);
    for (int i = 0; i < 5; i++) begin
      send_item(rand_word(), 1'b0);
    end
    write_size(agr_pkg::CFG_W'(3));
    send_item(32'hCAFE_0001, 1'b0);
    send_item(32'hCAFE_0002, 1'b1);

    // Shrinking the size inside a passing group ends that group.
    write_size(agr_pkg::CFG_W'(4));
    for (int i = 0; i < 6; i++) begin
      send_item(rand_word(), 1'b0);
    end
    write_size(agr_pkg::CFG_W'(1));
    send_item(32'h7FFF_FFFE, 1'b0);
    send_item(32'h8000_0000, 1'b1);

    // Random phases: new size, then whole sequences; some phases stop inside
    // a group so the next size change lands mid-group.
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      write_size(pick_size());
      k       = sb.group_len();
      idle_on = ($urandom_range(0, 3) != 0);
      n_seq   = $urandom_range(1, 3);
      for (int s = 0; s < int'(n_seq) && sent < RANDOM_ITEMS; s++) begin
        len       = $urandom_range(1, (k > 20) ? k + 8 : 3 * k + 3);
        if (sent + len > RANDOM_ITEMS) begin
          len = RANDOM_ITEMS - sent;
        end
        keep_open = (s == int'(n_seq) - 1) && ($urandom_range(0, 4) == 0);
        for (int j = 0; j < int'(len); j++) begin
          send_item(rand_word(), (j == int'(len) - 1) && !keep_open);
          sent++;
        end
      end
    end

    // Drain and let the pipeline settle before the verdict.
    wait_drained();
    repeat (TAIL_CYCLES) @(negedge clk);
    if (sb.pending() != 0) begin
      sb.report($sformatf("%0d predicted results never arrived", sb.pending()));
    end
    if (sb.mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
